### rtl/iclp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iclp_pkg
// Types and constants shared by the initialisation command list parser.
// ----------------------------------------------------------------------------
package iclp_pkg;

    // input item width
    localparam int unsigned BYTE_W      = 8;
    // result field widths
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned VALUE_W     = 9;
    localparam int unsigned ARG_COUNT_W = 7;
    // packed result data: value, arg_count, has_delay, zero padded to bytes
    localparam int unsigned OUT_FIELDS_W = VALUE_W + ARG_COUNT_W + 1;
    localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // argument count byte delay flag and delay codes
    localparam logic [BYTE_W-1:0]  DELAY_FLAG      = 8'h80;
    localparam logic [BYTE_W-1:0]  LONG_DELAY_CODE = 8'd255;
    localparam logic [VALUE_W-1:0] LONG_DELAY_MS   = 9'd500;

    // parser phase
    typedef enum logic [2:0] {
        PH_COUNT = 3'd0,
        PH_CMD   = 3'd1,
        PH_NARGS = 3'd2,
        PH_ARGS  = 3'd3,
        PH_DELAY = 3'd4
    } phase_t;

    // result kind
    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER = 2'd0,
        KIND_ARG    = 2'd1,
        KIND_DELAY  = 2'd2
    } kind_t;

endpackage : iclp_pkg
`default_nettype wire

### rtl/init_command_list_parser.sv
`default_nettype none
// An accepted byte's result is registered straight into the output register.
// Throughput: one byte per cycle; a new byte is taken while a result waits,
// provided the output register is drained in the same cycle.
// Reset: rst_n clears the phase, counters and output valid; the parser then
// expects the count byte of a new list.
// ----------------------------------------------------------------------------
// init_command_list_parser
// Parses a display initialisation command list byte by byte into command
// headers, argument bytes and delays in milliseconds.
// ----------------------------------------------------------------------------
module init_command_list_parser
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // list byte stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [iclp_pkg::BYTE_W-1:0]       s_axis_tdata,  // list_byte
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // value [8:0], arg_count [15:9], has_delay [16], zero [23:17]
    output logic [iclp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic [iclp_pkg::KIND_W-1:0]            m_axis_tuser,  // kind
    output logic                                   m_axis_tlast   // last_of_list
);
    import iclp_pkg::*;

    // parser state
    phase_t                   phase_reg, phase_next;
    logic [BYTE_W-1:0]        commands_left_reg, commands_left_next;
    logic [ARG_COUNT_W-1:0]   args_left_reg, args_left_next;
    logic                     delay_pending_reg, delay_pending_next;
    logic [BYTE_W-1:0]        held_command_reg, held_command_next;

    // result register
    logic                     out_valid_reg, out_valid_next;
    kind_t                    kind_reg, kind_next;
    logic [VALUE_W-1:0]       value_reg, value_next;
    logic [ARG_COUNT_W-1:0]   arg_count_reg, arg_count_next;
    logic                     has_delay_reg, has_delay_next;
    logic                     last_reg, last_next;

    logic                     in_accept;
    logic                     emit;
    logic [BYTE_W-1:0]        cmds_dec;
    logic [ARG_COUNT_W-1:0]   args_dec;
    logic [ARG_COUNT_W-1:0]   nargs;
    logic                     final_cmd;

    // handshake: take a byte whenever the result register is free or draining
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // shared decodes
    assign cmds_dec  = commands_left_reg - BYTE_W'(1);
    assign args_dec  = args_left_reg - ARG_COUNT_W'(1);
    assign nargs     = s_axis_tdata[ARG_COUNT_W-1:0];
    assign final_cmd = (commands_left_reg == BYTE_W'(1));

    // next state
    always_comb
    begin
        phase_next         = phase_reg;
        commands_left_next = commands_left_reg;
        args_left_next     = args_left_reg;
        delay_pending_next = delay_pending_reg;
        held_command_next  = held_command_reg;
        if (in_accept)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    held_command_next = s_axis_tdata;
                    phase_next        = PH_NARGS;
                end
                PH_NARGS:
                begin
                    args_left_next     = nargs;
                    delay_pending_next = |(s_axis_tdata & DELAY_FLAG);
                    if (nargs != '0)
                        phase_next = PH_ARGS;
                    else if (|(s_axis_tdata & DELAY_FLAG))
                        phase_next = PH_DELAY;
                    else
                    begin
                        commands_left_next = cmds_dec;
                        phase_next = (cmds_dec == '0) ? PH_COUNT : PH_CMD;
                    end
                end
                PH_ARGS:
                begin
                    args_left_next = args_dec;
                    if (args_dec == '0)
                    begin
                        if (delay_pending_reg)
                            phase_next = PH_DELAY;
                        else
                        begin
                            commands_left_next = cmds_dec;
                            phase_next = (cmds_dec == '0) ? PH_COUNT : PH_CMD;
                        end
                    end
                end
                PH_DELAY:
                begin
                    delay_pending_next = 1'b0;
                    commands_left_next = cmds_dec;
                    phase_next = (cmds_dec == '0) ? PH_COUNT : PH_CMD;
                end
                default:
                begin
                    // count byte, also taken on any unused phase code
                    commands_left_next = s_axis_tdata;
                    args_left_next     = '0;
                    delay_pending_next = 1'b0;
                    phase_next = (s_axis_tdata == '0) ? PH_COUNT : PH_CMD;
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        emit           = 1'b0;
        kind_next      = kind_reg;
        value_next     = value_reg;
        arg_count_next = arg_count_reg;
        has_delay_next = has_delay_reg;
        last_next      = last_reg;
        unique case (phase_reg)
            PH_NARGS:
            begin
                emit           = 1'b1;
                kind_next      = KIND_HEADER;
                value_next     = {1'b0, held_command_reg};
                arg_count_next = nargs;
                has_delay_next = |(s_axis_tdata & DELAY_FLAG);
                last_next      = final_cmd && (nargs == '0)
                                 && !(|(s_axis_tdata & DELAY_FLAG));
            end
            PH_ARGS:
            begin
                emit           = 1'b1;
                kind_next      = KIND_ARG;
                value_next     = {1'b0, s_axis_tdata};
                arg_count_next = '0;
                has_delay_next = 1'b0;
                last_next      = final_cmd && (args_dec == '0) && !delay_pending_reg;
            end
            PH_DELAY:
            begin
                emit           = 1'b1;
                kind_next      = KIND_DELAY;
                value_next     = (s_axis_tdata == LONG_DELAY_CODE) ? LONG_DELAY_MS
                                                                   : {1'b0, s_axis_tdata};
                arg_count_next = '0;
                has_delay_next = 1'b0;
                last_next      = final_cmd;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        // output valid: set by a new result, cleared once taken
        if (in_accept)
            out_valid_next = emit;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_COUNT;
            commands_left_reg <= '0;
            args_left_reg     <= '0;
            delay_pending_reg <= 1'b0;
            held_command_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            commands_left_reg <= commands_left_next;
            args_left_reg     <= args_left_next;
            delay_pending_reg <= delay_pending_next;
            held_command_reg  <= held_command_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            kind_reg      <= kind_next;
            value_reg     <= value_next;
            arg_count_reg <= arg_count_next;
            has_delay_reg <= has_delay_next;
            last_reg      <= last_next;
        end
    end

    // output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                            has_delay_reg, arg_count_reg, value_reg};
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tlast  = last_reg;

endmodule : init_command_list_parser
`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the initialisation command list parser against a cycle-free
// prediction of its results. Byte items go in as whole command lists, a
// directed set first and random lists after, with bursty input and a
// patterned output stall; every result item is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    import iclp_pkg::*;

    localparam int unsigned TARGET_BYTES = 1550;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    // one result item as the parser should present it
    typedef struct packed {
        kind_t                  kind;
        logic [VALUE_W-1:0]     value;
        logic [ARG_COUNT_W-1:0] arg_count;
        logic                   has_delay;
        logic                   last;
    } list_result_t;

    // ------------------------------------------------------------------------
    // parser prediction and result checking
    // ------------------------------------------------------------------------
    class list_scoreboard;
        phase_t                 phase;
        logic [BYTE_W-1:0]      commands_left;
        logic [ARG_COUNT_W-1:0] args_left;
        logic                   delay_pending;
        logic [BYTE_W-1:0]      held_command;
        list_result_t           pending_results[$];
        int unsigned            errors;
        int unsigned            results_seen;

        function new();
            phase         = PH_COUNT;
            commands_left = '0;
            args_left     = '0;
            delay_pending = 1'b0;
            held_command  = '0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        // a command is complete: next command or back to the count byte
        function void end_command();
            commands_left = commands_left - 1'b1;
            phase = (commands_left == '0) ? PH_COUNT : PH_CMD;
        endfunction

        // advance the parse by one accepted byte, queueing any result
        function void note_byte(logic [BYTE_W-1:0] b);
            list_result_t r;
            bit           produced;
            r        = '0;
            produced = 1'b0;
            case (phase)
                PH_CMD:
                begin
                    held_command = b;
                    phase        = PH_NARGS;
                end
                PH_NARGS:
                begin
                    args_left     = b[ARG_COUNT_W-1:0];
                    delay_pending = (b & DELAY_FLAG) != '0;
                    r.kind        = KIND_HEADER;
                    r.value       = {1'b0, held_command};
                    r.arg_count   = args_left;
                    r.has_delay   = delay_pending;
                    r.last        = (commands_left == 8'd1) && (args_left == '0)
                                    && !delay_pending;
                    produced      = 1'b1;
                    if (args_left != '0)
                        phase = PH_ARGS;
                    else if (delay_pending)
                        phase = PH_DELAY;
                    else
                        end_command();
                end
                PH_ARGS:
                begin
                    args_left = args_left - 1'b1;
                    r.kind    = KIND_ARG;
                    r.value   = {1'b0, b};
                    r.last    = (commands_left == 8'd1) && (args_left == '0)
                                && !delay_pending;
                    produced  = 1'b1;
                    if (args_left == '0)
                    begin
                        if (delay_pending)
                            phase = PH_DELAY;
                        else
                            end_command();
                    end
                end
                PH_DELAY:
                begin
                    r.kind        = KIND_DELAY;
                    r.value       = (b == LONG_DELAY_CODE) ? LONG_DELAY_MS : {1'b0, b};
                    r.last        = (commands_left == 8'd1);
                    produced      = 1'b1;
                    delay_pending = 1'b0;
                    end_command();
                end
                default:
                begin
                    // count byte; a zero count leaves the parser waiting
                    commands_left = b;
                    args_left     = '0;
                    delay_pending = 1'b0;
                    phase         = (b == '0) ? PH_COUNT : PH_CMD;
                end
            endcase
            if (produced)
                pending_results.push_back(r);
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("result %0d: %s mismatch, got %0d, expected %0d",
                     results_seen, what, got, want);
            errors++;
        endtask

        // compare one accepted result item with the oldest prediction
        task check_result(logic [OUT_TDATA_W-1:0] data, logic [KIND_W-1:0] user,
                          logic last);
            list_result_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected item", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (user !== want.kind)
                    report_mismatch("kind", 32'(user), 32'(want.kind));
                if (data[VALUE_W-1:0] !== want.value)
                    report_mismatch("value", 32'(data[VALUE_W-1:0]), 32'(want.value));
                if (data[VALUE_W +: ARG_COUNT_W] !== want.arg_count)
                    report_mismatch("arg_count", 32'(data[VALUE_W +: ARG_COUNT_W]),
                                    32'(want.arg_count));
                if (data[OUT_FIELDS_W-1] !== want.has_delay)
                    report_mismatch("has_delay", 32'(data[OUT_FIELDS_W-1]),
                                    32'(want.has_delay));
                if (data[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0)
                    report_mismatch("padding", 32'(data[OUT_TDATA_W-1:OUT_FIELDS_W]), 0);
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
            results_seen++;
        endtask

        task check_drained();
            if (pending_results.size() != 0)
                report_mismatch("results missing", 0, pending_results.size());
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic [BYTE_W-1:0]        s_axis_tdata  = '0;
    logic                     m_axis_tready = 1'b0;
    logic                     s_axis_tready;
    logic                     m_axis_tvalid;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [KIND_W-1:0]        m_axis_tuser;
    logic                     m_axis_tlast;

    list_scoreboard           list_sb;
    int unsigned              bytes_sent  = 0;
    int unsigned              burst_left  = 0;
    logic [9:0]               stall_cycle = '0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    init_command_list_parser u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // receiver stall pattern: free running, light, heavy, then periodic
    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1'b1;
        case (stall_cycle[9:8])
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (stall_cycle[2:0] != 3'd5) && !stall_cycle[4];
        endcase
    end

    // handshake monitor on both sides
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            list_sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            list_sb.note_byte(s_axis_tdata);
    end

    // ------------------------------------------------------------------------
    // list byte driver
    // ------------------------------------------------------------------------
    // send one byte item; bursts of random length with random gaps between
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    // one well-formed list with random commands, arguments and delays
    task automatic send_list(input logic [BYTE_W-1:0] n_commands, input bit short_commands);
        logic [ARG_COUNT_W-1:0] n_args;
        bit                     with_delay;
        int                     pick;
        send_byte(n_commands);
        for (int c = 0; c < n_commands; c++)
        begin
            pick = $urandom_range(0, 39);
            if (short_commands)
                n_args = ARG_COUNT_W'($urandom_range(0, 2));
            else if (pick == 0)
                n_args = 7'd127;
            else if (pick < 4)
                n_args = ARG_COUNT_W'($urandom_range(5, 20));
            else
                n_args = ARG_COUNT_W'($urandom_range(0, 4));
            with_delay = ($urandom_range(0, 2) == 0);
            send_byte(BYTE_W'($urandom_range(0, 255)));
            send_byte({with_delay, n_args});
            for (int a = 0; a < n_args; a++)
                send_byte(BYTE_W'($urandom_range(0, 255)));
            if (with_delay)
                send_byte(($urandom_range(0, 3) == 0) ? LONG_DELAY_CODE
                                                      : BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[init_command_list_parser] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        logic [BYTE_W-1:0] directed_bytes[$];
        list_sb = new();
        // zero count; bare command; long delay code after an argument;
        // delay-only command ending the list; arguments ending the list;
        // delay of one below the long code
        directed_bytes = '{8'h00,
                           8'h01, 8'h00, 8'h00,
                           8'h02, 8'hFF, 8'h81, 8'hFF, 8'hFF, 8'h5A, 8'h80, 8'h00,
                           8'h01, 8'hA5, 8'h02, 8'h00, 8'h55,
                           8'h01, 8'h3C, 8'h80, 8'hFE};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        // largest command count, kept to short commands
        send_list(8'd255, 1'b1);

        // random lists, now and then an empty one
        while (bytes_sent < TARGET_BYTES)
        begin
            if ($urandom_range(0, 19) == 0)
                send_list(8'd0, 1'b0);
            else
                send_list(BYTE_W'($urandom_range(1, 6)), 1'b0);
        end
        s_axis_tvalid <= 1'b0;

        while (list_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        list_sb.check_drained();

        if (list_sb.errors == 0)
            $display("[init_command_list_parser] OK");
        else
            $display("[init_command_list_parser] ERROR");
        $finish;
    end

endmodule

### files.f
rtl/iclp_pkg.sv
rtl/init_command_list_parser.sv
dv/testbench.sv
